### rtl/slot_buffer_allocator_queue_assert.svh
// Assertion macros for the slot buffer allocator queue.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SLOT_BUFFER_ALLOCATOR_QUEUE_ASSERT_SVH
`define SLOT_BUFFER_ALLOCATOR_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property, sampled on the clock, off while reset is low
`define SBAQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbaq: assertion failed");
// Same-cycle implication
`define SBAQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `SBAQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define SBAQ_ASSERT(lbl, clk, rst_n, prop)
`define SBAQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/sbaq_pkg.sv
// Package for the slot buffer allocator queue: field widths, codes,
// microcode word layout and the microcode program. No dependencies.
`default_nettype none

package sbaq_pkg;

  // Item field widths
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned UPC_W  = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_RESET   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIRST   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXT    = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_END     = 3'd2,
    ST_BAD     = 3'd3,
    ST_NOTUSED = 3'd4
  } status_e;

  // Datapath operation of one microcode step
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_RESET,
    UOP_ALLOC_PREP,
    UOP_ALLOC_FIN,
    UOP_REL_INIT,
    UOP_REL_READ,
    UOP_REL_STEP,
    UOP_REL_UNLINK,
    UOP_REL_PUSH,
    UOP_FIRST_READ,
    UOP_FIRST_FIN,
    UOP_NEXT_READ,
    UOP_NEXT_LEN,
    UOP_NEXT_FIN,
    UOP_NEXT_CLEAR
  } uop_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_FREE_BAD,
    C_SLOT_BAD,
    C_WALK_OVER,
    C_CUR_NE_SLOT,
    C_HEAD_BAD,
    C_CUR_END,
    C_LINK_BAD
  } cond_e;

  typedef struct packed {
    uop_e    op;
    cond_e   cond;
    upc_t    target;
    logic    fin;
    status_e status;
  } ucode_t;

  // Program addresses
  localparam upc_t UA_RESET        = 5'd0;
  localparam upc_t UA_ALLOC        = 5'd1;
  localparam upc_t UA_ALLOC_FIN    = 5'd2;
  localparam upc_t UA_REL          = 5'd3;
  localparam upc_t UA_REL_READ     = 5'd4;
  localparam upc_t UA_REL_STEP     = 5'd5;
  localparam upc_t UA_REL_UNLINK   = 5'd6;
  localparam upc_t UA_REL_PUSH     = 5'd7;
  localparam upc_t UA_FIRST        = 5'd8;
  localparam upc_t UA_FIRST_FIN    = 5'd9;
  localparam upc_t UA_NEXT         = 5'd10;
  localparam upc_t UA_NEXT_LEN     = 5'd11;
  localparam upc_t UA_NEXT_FIN     = 5'd12;
  localparam upc_t UA_NEXT_END     = 5'd13;
  localparam upc_t UA_EMIT_FULL    = 5'd14;
  localparam upc_t UA_EMIT_BAD     = 5'd15;
  localparam upc_t UA_EMIT_NOTUSED = 5'd16;
  localparam upc_t UA_EMIT_END     = 5'd17;

  function automatic ucode_t mk_word(uop_e op, cond_e cond, upc_t target,
                                     logic fin, status_e status);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.fin    = fin;
    w.status = status;
    return w;
  endfunction

  // Microcode ROM
  function automatic ucode_t ucode_word(upc_t a);
    ucode_t w;
    unique case (a)
      UA_RESET:        w = mk_word(UOP_RESET, C_NEVER, UA_RESET, 1'b1, ST_OK);
      UA_ALLOC:        w = mk_word(UOP_ALLOC_PREP, C_FREE_BAD, UA_EMIT_FULL, 1'b0, ST_OK);
      UA_ALLOC_FIN:    w = mk_word(UOP_ALLOC_FIN, C_NEVER, UA_RESET, 1'b1, ST_OK);
      UA_REL:          w = mk_word(UOP_REL_INIT, C_SLOT_BAD, UA_EMIT_BAD, 1'b0, ST_OK);
      UA_REL_READ:     w = mk_word(UOP_REL_READ, C_WALK_OVER, UA_EMIT_NOTUSED, 1'b0, ST_OK);
      UA_REL_STEP:     w = mk_word(UOP_REL_STEP, C_CUR_NE_SLOT, UA_REL_READ, 1'b0, ST_OK);
      UA_REL_UNLINK:   w = mk_word(UOP_REL_UNLINK, C_NEVER, UA_RESET, 1'b0, ST_OK);
      UA_REL_PUSH:     w = mk_word(UOP_REL_PUSH, C_NEVER, UA_RESET, 1'b1, ST_OK);
      UA_FIRST:        w = mk_word(UOP_FIRST_READ, C_HEAD_BAD, UA_EMIT_END, 1'b0, ST_OK);
      UA_FIRST_FIN:    w = mk_word(UOP_FIRST_FIN, C_NEVER, UA_RESET, 1'b1, ST_OK);
      UA_NEXT:         w = mk_word(UOP_NEXT_READ, C_CUR_END, UA_NEXT_END, 1'b0, ST_OK);
      UA_NEXT_LEN:     w = mk_word(UOP_NEXT_LEN, C_LINK_BAD, UA_NEXT_END, 1'b0, ST_OK);
      UA_NEXT_FIN:     w = mk_word(UOP_NEXT_FIN, C_NEVER, UA_RESET, 1'b1, ST_OK);
      UA_NEXT_END:     w = mk_word(UOP_NEXT_CLEAR, C_NEVER, UA_RESET, 1'b1, ST_END);
      UA_EMIT_FULL:    w = mk_word(UOP_NOP, C_NEVER, UA_RESET, 1'b1, ST_FULL);
      UA_EMIT_BAD:     w = mk_word(UOP_NOP, C_NEVER, UA_RESET, 1'b1, ST_BAD);
      UA_EMIT_NOTUSED: w = mk_word(UOP_NOP, C_NEVER, UA_RESET, 1'b1, ST_NOTUSED);
      default:         w = mk_word(UOP_NOP, C_NEVER, UA_RESET, 1'b1, ST_END);
    endcase
    return w;
  endfunction

  // Dispatch: first step of each action; unknown codes answer end
  function automatic upc_t ucode_entry(logic [ACT_W-1:0] act);
    upc_t a;
    unique case (act)
      ACT_RESET:   a = UA_RESET;
      ACT_ALLOC:   a = UA_ALLOC;
      ACT_RELEASE: a = UA_REL;
      ACT_FIRST:   a = UA_FIRST;
      ACT_NEXT:    a = UA_NEXT;
      default:     a = UA_EMIT_END;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/sbaq_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on sbaq_pkg for the field widths.
`default_nettype none

interface sbaq_req_if import sbaq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [LEN_W-1:0]  length;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, action, length, slot, input ready);
  modport sink   (input valid, action, length, slot, output ready);
endinterface

interface sbaq_rsp_if import sbaq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_out;
  logic [LEN_W-1:0]  length_out;

  modport source (output valid, status, slot_out, length_out, input ready);
  modport sink   (input valid, status, slot_out, length_out, output ready);
endinterface

`default_nettype wire

### rtl/sbaq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbaq_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/slot_buffer_allocator_queue.sv
// Slot buffer allocator queue: a microcode sequencer over a link table RAM and a length RAM.
// Each item is accepted and then run as a sequence of microcode steps; a release walks
// the used list from its head until it finds the slot or leaves the list. Each step
// issues at most one registered link table read, and a waiting result holds the last
// step. Async reset and the reset action rebuild the lists at once through per-entry
// valid bits on the link table; there is no clearing pass.
`default_nettype none
`include "slot_buffer_allocator_queue_assert.svh"

module slot_buffer_allocator_queue import sbaq_pkg::*; #(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sbaq_req_if.sink    in_i,
  sbaq_rsp_if.source  out_o
);

  localparam int unsigned AW = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOTS_V = SLOT_W'(SLOTS);
  localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);

  function automatic logic slot_bad(logic [SLOT_W-1:0] s);
    return (s == '0) || (s > SLOTS_V);
  endfunction

  // reset contents of a link table entry
  function automatic logic [SLOT_W-1:0] link_init(logic [AW-1:0] a);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'(a);
    return ((s != '0) && (s < SLOTS_V)) ? s + SLOT_W'(1) : '0;
  endfunction

  // control state
  logic              busy_q, busy_d;
  upc_t              upc_q, upc_d;
  logic [SLOT_W-1:0] free_head_q, free_head_d;
  logic [SLOT_W-1:0] used_head_q, used_head_d;
  logic [SLOT_W-1:0] used_tail_q, used_tail_d;
  logic [SLOT_W-1:0] walk_q, walk_d;
  logic [SLOTS:0]    lv_q, lv_d;
  logic              lrd_valid_q, lrd_valid_d;
  logic              out_valid_q, out_valid_d;

  // payload state
  logic [LEN_W-1:0]  len_q, len_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] tmp_q, tmp_d;
  logic [SLOT_W-1:0] prev_q, prev_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] steps_q, steps_d;
  logic [SLOT_W-1:0] lrd_rst_q, lrd_rst_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  // RAM ports
  logic              lk_we, lk_re;
  logic [AW-1:0]     lk_waddr, lk_raddr;
  logic [SLOT_W-1:0] lk_wdata, lk_rdata;
  logic              ln_we, ln_re;
  logic [AW-1:0]     ln_waddr, ln_raddr;
  logic [LEN_W-1:0]  ln_wdata, ln_rdata;

  ucode_t            cw;
  logic              exec;
  logic              jump;
  logic              in_acc;
  logic [SLOT_W-1:0] link_rd;
  logic [LEN_W-1:0]  len_sat;

  sbaq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS + 1)) u_link (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  sbaq_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS + 1)) u_len (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .re_i    (ln_re),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  // handshakes and current control word
  assign cw       = ucode_word(upc_q);
  assign in_acc   = in_i.valid && !busy_q;
  assign exec     = busy_q && (!cw.fin || !out_valid_q || out_o.ready);
  assign link_rd  = lrd_valid_q ? lk_rdata : lrd_rst_q;
  assign len_sat  = ({6'd0, in_i.length} > MAX_LEN_V) ? MAX_LEN_V[LEN_W-1:0] : in_i.length;

  assign in_i.ready       = !busy_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_out   = out_slot_q;
  assign out_o.length_out = out_len_q;

  // jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_FREE_BAD:    jump = slot_bad(free_head_q);
      C_SLOT_BAD:    jump = slot_bad(slot_q);
      C_WALK_OVER:   jump = slot_bad(cur_q) || (steps_q == SLOTS_V);
      C_CUR_NE_SLOT: jump = (cur_q != slot_q);
      C_HEAD_BAD:    jump = slot_bad(used_head_q);
      C_CUR_END:     jump = slot_bad(walk_q) || (walk_q == used_tail_q);
      C_LINK_BAD:    jump = slot_bad(link_rd);
    endcase
  end

  // sequencer and datapath
  always_comb begin
    busy_d       = busy_q;
    upc_d        = upc_q;
    free_head_d  = free_head_q;
    used_head_d  = used_head_q;
    used_tail_d  = used_tail_q;
    walk_d       = walk_q;
    lv_d         = lv_q;
    lrd_valid_d  = lrd_valid_q;
    out_valid_d  = out_valid_q;
    len_d        = len_q;
    slot_d       = slot_q;
    tmp_d        = tmp_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    lrd_rst_d    = lrd_rst_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_len_d    = out_len_q;
    lk_we        = 1'b0;
    lk_waddr     = '0;
    lk_wdata     = '0;
    lk_re        = 1'b0;
    lk_raddr     = '0;
    ln_we        = 1'b0;
    ln_waddr     = '0;
    ln_wdata     = '0;
    ln_re        = 1'b0;
    ln_raddr     = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // take a new item
    if (in_acc) begin
      busy_d = 1'b1;
      upc_d  = ucode_entry(in_i.action);
      len_d  = len_sat;
      slot_d = in_i.slot;
    end

    if (exec) begin
      upc_d = jump ? cw.target : upc_q + upc_t'(1);
      if (cw.fin) begin
        busy_d       = 1'b0;
        out_valid_d  = 1'b1;
        out_status_d = cw.status;
        out_slot_d   = '0;
        out_len_d    = '0;
      end

      unique case (cw.op)
        UOP_NOP: begin
        end
        UOP_RESET: begin
          lv_d        = '0;
          free_head_d = SLOT_W'(1);
          used_head_d = '0;
          used_tail_d = '0;
          walk_d      = '0;
        end
        UOP_ALLOC_PREP: begin
          if (!slot_bad(free_head_q)) begin
            tmp_d    = free_head_q;
            lk_re    = 1'b1;
            lk_raddr = AW'(free_head_q);
            ln_we    = 1'b1;
            ln_waddr = AW'(free_head_q);
            ln_wdata = len_q;
            // append behind the current tail
            if (used_head_q != '0) begin
              lk_we    = 1'b1;
              lk_waddr = AW'(used_tail_q);
              lk_wdata = free_head_q;
            end
          end
        end
        UOP_ALLOC_FIN: begin
          free_head_d = link_rd;
          lk_we       = 1'b1;
          lk_waddr    = AW'(tmp_q);
          lk_wdata    = '0;
          if (used_head_q == '0) begin
            used_head_d = tmp_q;
          end
          used_tail_d = tmp_q;
          out_slot_d  = tmp_q;
          out_len_d   = len_q;
        end
        UOP_REL_INIT: begin
          prev_d  = '0;
          cur_d   = used_head_q;
          steps_d = '0;
        end
        UOP_REL_READ: begin
          lk_re    = 1'b1;
          lk_raddr = AW'(cur_q);
        end
        UOP_REL_STEP: begin
          if (cur_q != slot_q) begin
            prev_d  = cur_q;
            cur_d   = link_rd;
            steps_d = steps_q + SLOT_W'(1);
          end else begin
            tmp_d = link_rd;
          end
        end
        UOP_REL_UNLINK: begin
          if (prev_q == '0) begin
            used_head_d = tmp_q;
          end else begin
            lk_we    = 1'b1;
            lk_waddr = AW'(prev_q);
            lk_wdata = tmp_q;
          end
          if (used_tail_q == slot_q) begin
            used_tail_d = prev_q;
          end
          if (walk_q == slot_q) begin
            walk_d = '0;
          end
        end
        UOP_REL_PUSH: begin
          lk_we       = 1'b1;
          lk_waddr    = AW'(slot_q);
          lk_wdata    = free_head_q;
          free_head_d = slot_q;
          out_slot_d  = slot_q;
        end
        UOP_FIRST_READ: begin
          ln_re    = 1'b1;
          ln_raddr = AW'(used_head_q);
        end
        UOP_FIRST_FIN: begin
          walk_d     = used_head_q;
          out_slot_d = used_head_q;
          out_len_d  = ln_rdata;
        end
        UOP_NEXT_READ: begin
          lk_re    = 1'b1;
          lk_raddr = AW'(walk_q);
        end
        UOP_NEXT_LEN: begin
          tmp_d    = link_rd;
          ln_re    = 1'b1;
          ln_raddr = AW'(link_rd);
        end
        UOP_NEXT_FIN: begin
          walk_d     = tmp_q;
          out_slot_d = tmp_q;
          out_len_d  = ln_rdata;
        end
        UOP_NEXT_CLEAR: begin
          walk_d = '0;
        end
      endcase

      // link table valid bits track written entries
      if (lk_we) begin
        lv_d[lk_waddr] = 1'b1;
      end
      if (lk_re) begin
        lrd_valid_d = lv_q[lk_raddr];
        lrd_rst_d   = link_init(lk_raddr);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UA_RESET;
      free_head_q <= SLOT_W'(1);
      used_head_q <= '0;
      used_tail_q <= '0;
      walk_q      <= '0;
      lv_q        <= '0;
      lrd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
      used_tail_q <= used_tail_d;
      walk_q      <= walk_d;
      lv_q        <= lv_d;
      lrd_valid_q <= lrd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    slot_q       <= slot_d;
    tmp_q        <= tmp_d;
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    lrd_rst_q    <= lrd_rst_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_len_q    <= out_len_d;
  end

  // used list is empty at both ends or at neither
  `SBAQ_ASSERT(a_used_ends, clk_i, rst_ni, (used_head_q == '0) == (used_tail_q == '0))
  // a finishing step never overwrites a result that waits
  `SBAQ_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, exec && cw.fin, !out_valid_q || out_o.ready)
  // a result appears only as an item finishes
  `SBAQ_ASSERT_IMP(a_rsp_from_item, clk_i, rst_ni, $rose(out_valid_q), $past(busy_q))
  // the release walk never exceeds the slot count
  `SBAQ_ASSERT_IMP(a_walk_bound, clk_i, rst_ni, busy_q && cw.op == UOP_REL_STEP, steps_q < SLOTS_V)

endmodule

`default_nettype wire
